// ===== rtl/c2e_pkg.sv =====
// Shared types, constants and tables for the calendar to epoch seconds converter.
package c2e_pkg;

  // Register stages from the input capture to the output register.
  localparam int NUM_STAGES = 6;

  localparam logic [9:0]  EPOCH_YEAR_OFFSET = 10'd70;
  // The calendar year minus one is year_since_1900 plus this.
  localparam logic [11:0] PREV_YEAR_BASE    = 12'd1899;
  // Leap years in 1..1969 under the Gregorian rule.
  localparam logic [9:0]  LEAPS_BEFORE_EPOCH = 10'd477;
  localparam logic [18:0] DAYS_PER_YEAR     = 19'd365;
  localparam logic [11:0] YEARS_PER_CENTURY = 12'd100;

  // Reciprocal of 100, exact for every year value in range.
  localparam logic [24:0] DIV100_MUL   = 25'd5243;
  localparam int          DIV100_SHIFT = 19;
  // Reciprocal of 7, exact for every day count in range.
  localparam logic [38:0] DIV7_MUL     = 39'd599187;
  localparam int          DIV7_SHIFT   = 22;

  localparam logic signed [17:0] SECS_PER_DAY  = 18'sd86400;
  localparam logic [16:0]        SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0]        SECS_PER_MIN  = 17'd60;
  // 1970-01-01 was a Thursday.
  localparam logic signed [19:0] EPOCH_WEEKDAY = 20'sd4;
  localparam logic [18:0]        DAYS_PER_WEEK = 19'd7;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // Days before the first of the month; codes above December count as December.
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      default: days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

// ===== rtl/c2e_in_if.sv =====
// Request channel carrying one broken-down date and time.
interface c2e_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] year_since_1900;
  logic [3:0] month;
  logic [4:0] day_of_month;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;

  modport source (
    output valid, year_since_1900, month, day_of_month, hour, minute, second,
    input  ready
  );
  modport sink (
    input  valid, year_since_1900, month, day_of_month, hour, minute, second,
    output ready
  );
endinterface

// ===== rtl/c2e_out_if.sv =====
// Result channel carrying the epoch time, weekday and day of year.
interface c2e_out_if;
  logic        valid;
  logic        ready;
  logic [34:0] epoch_seconds;
  logic [2:0]  weekday;
  logic [8:0]  year_day;
  logic        before_epoch;

  modport source (
    output valid, epoch_seconds, weekday, year_day, before_epoch,
    input  ready
  );
  modport sink (
    input  valid, epoch_seconds, weekday, year_day, before_epoch,
    output ready
  );
endinterface

// ===== rtl/c2e_pipe_ctrl.sv =====
// Valid bits and per-stage load enables for the elastic conversion pipeline.
module c2e_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_ready,
  output c2e_pkg::pipe_ctl_t   ctl
);

  logic [c2e_pkg::NUM_STAGES-1:0] valid_r;
  logic [c2e_pkg::NUM_STAGES-1:0] valid_nxt;
  logic [c2e_pkg::NUM_STAGES-1:0] load;
  logic [c2e_pkg::NUM_STAGES-1:0] upstream;

  // A stage may load when it is empty or its content moves on in this cycle,
  // so bubbles are squeezed out even while the output is stalled.
  always_comb begin
    load[c2e_pkg::NUM_STAGES-1] = !valid_r[c2e_pkg::NUM_STAGES-1] || out_ready;
    for (int i = c2e_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid_r[i] || load[i+1];
    end
  end

  assign upstream  = {valid_r[c2e_pkg::NUM_STAGES-2:0], in_valid};
  assign valid_nxt = (load & upstream) | (~load & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.load  = load;
  assign ctl.valid = valid_r;

endmodule

// ===== rtl/calendar_to_epoch_seconds.sv =====
// Top level: pipelined conversion of a calendar date and time to Unix seconds.
//
// Usage: a request on in_if carries year_since_1900, month, day_of_month,
// hour, minute and second; it is taken at a clock edge where valid and
// ready are both high. Each request yields exactly one result on out_if:
// epoch_seconds, weekday (Sunday is 0), year_day and before_epoch. Years
// before 1970 give before_epoch high and all other fields zero.
// An accepted request passes in order through six register stages
// (capture, reciprocal products, leap and day sums, day count, seconds
// and week products, output register) to out_if.valid. Throughput is
// one request per cycle while out_if.ready stays high.
// Reset (rst_n low at a clock edge) empties the pipeline; nothing is in
// flight afterwards. When the receiver holds out_if.ready low, the output
// register keeps its result and the stages behind it keep filling until
// every stage holds a request; only then does in_if.ready fall. No request
// is dropped or repeated.
module calendar_to_epoch_seconds (
  input logic         clk,
  input logic         rst_n,
  c2e_in_if.sink      in_if,
  c2e_out_if.source   out_if
);

  c2e_pkg::pipe_ctl_t ctl;

  c2e_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .out_ready (out_if.ready),
    .ctl       (ctl)
  );

  assign in_if.ready  = ctl.load[0];
  assign out_if.valid = ctl.valid[c2e_pkg::NUM_STAGES-1];

  // Stage 1: capture.
  logic [9:0] s1_ys_r;
  logic [3:0] s1_mon_r;
  logic [4:0] s1_mday_r;
  logic [4:0] s1_hour_r;
  logic [5:0] s1_min_r;
  logic [5:0] s1_sec_r;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_ys_r   <= in_if.year_since_1900;
      s1_mon_r  <= in_if.month;
      s1_mday_r <= in_if.day_of_month;
      s1_hour_r <= in_if.hour;
      s1_min_r  <= in_if.minute;
      s1_sec_r  <= in_if.second;
    end
  end

  // Stage 2: reciprocal products for the century counts, month offset, time of day.
  logic [11:0] s2_prev_nxt, s2_year_nxt;
  logic [24:0] s2_pprev_nxt, s2_pyear_nxt;
  logic [9:0]  s2_base_nxt, s2_yoff_nxt;
  logic [16:0] s2_hms_nxt;
  logic        s2_err_nxt, s2_late_nxt, s2_ys4_nxt;

  always_comb begin
    s2_prev_nxt  = 12'(s1_ys_r) + c2e_pkg::PREV_YEAR_BASE;
    s2_year_nxt  = s2_prev_nxt + 12'd1;
    s2_pprev_nxt = 25'(s2_prev_nxt) * c2e_pkg::DIV100_MUL;
    s2_pyear_nxt = 25'(s2_year_nxt) * c2e_pkg::DIV100_MUL;
    // Day zero of January gives minus one; the 10-bit value is two's complement.
    s2_base_nxt  = 10'(c2e_pkg::days_before_month(s1_mon_r)) + 10'(s1_mday_r) - 10'd1;
    s2_yoff_nxt  = s1_ys_r - c2e_pkg::EPOCH_YEAR_OFFSET;
    s2_hms_nxt   = 17'(s1_hour_r) * c2e_pkg::SECS_PER_HOUR
                 + 17'(s1_min_r) * c2e_pkg::SECS_PER_MIN + 17'(s1_sec_r);
    s2_err_nxt   = s1_ys_r < c2e_pkg::EPOCH_YEAR_OFFSET;
    s2_late_nxt  = s1_mon_r > 4'd1;
    s2_ys4_nxt   = s1_ys_r[1:0] == 2'b00;
  end

  logic [11:0] s2_year_r;
  logic [9:0]  s2_div4_r;
  logic [24:0] s2_pprev_r, s2_pyear_r;
  logic [9:0]  s2_base_r, s2_yoff_r;
  logic [16:0] s2_hms_r;
  logic        s2_err_r, s2_late_r, s2_ys4_r;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_year_r  <= s2_year_nxt;
      s2_div4_r  <= s2_prev_nxt[11:2];
      s2_pprev_r <= s2_pprev_nxt;
      s2_pyear_r <= s2_pyear_nxt;
      s2_base_r  <= s2_base_nxt;
      s2_yoff_r  <= s2_yoff_nxt;
      s2_hms_r   <= s2_hms_nxt;
      s2_err_r   <= s2_err_nxt;
      s2_late_r  <= s2_late_nxt;
      s2_ys4_r   <= s2_ys4_nxt;
    end
  end

  // Stage 3: leap year test, leap days since 1970, days of whole years.
  logic [5:0]  s3_qprev, s3_qyear;
  logic        s3_century, s3_leap;
  logic [9:0]  s3_leaps;
  logic [18:0] s3_dyear_nxt;
  logic [9:0]  s3_yday_nxt;

  always_comb begin
    s3_qprev     = s2_pprev_r[24:c2e_pkg::DIV100_SHIFT];
    s3_qyear     = s2_pyear_r[24:c2e_pkg::DIV100_SHIFT];
    s3_century   = s2_year_r == 12'(12'(s3_qyear) * c2e_pkg::YEARS_PER_CENTURY);
    // Divisible by 400 means a century whose century count is a multiple of four.
    s3_leap      = s2_ys4_r && (!s3_century || (s3_qyear[1:0] == 2'b00));
    s3_leaps     = s2_div4_r - 10'(s3_qprev) + 10'(s3_qprev[5:2])
                 - c2e_pkg::LEAPS_BEFORE_EPOCH;
    s3_dyear_nxt = 19'(s2_yoff_r) * c2e_pkg::DAYS_PER_YEAR + 19'(s3_leaps);
    s3_yday_nxt  = s2_base_r + 10'(s3_leap && s2_late_r);
  end

  logic [18:0] s3_dyear_r;
  logic [9:0]  s3_yday_r;
  logic [16:0] s3_hms_r;
  logic        s3_err_r;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_dyear_r <= s3_dyear_nxt;
      s3_yday_r  <= s3_yday_nxt;
      s3_hms_r   <= s2_hms_r;
      s3_err_r   <= s2_err_r;
    end
  end

  // Stage 4: signed day count.
  logic signed [19:0] s4_days_nxt;

  assign s4_days_nxt = $signed({1'b0, s3_dyear_r}) + $signed({{10{s3_yday_r[9]}}, s3_yday_r});

  logic signed [19:0] s4_days_r;
  logic [9:0]         s4_yday_r;
  logic [16:0]        s4_hms_r;
  logic               s4_err_r;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_days_r <= s4_days_nxt;
      s4_yday_r <= s3_yday_r;
      s4_hms_r  <= s3_hms_r;
      s4_err_r  <= s3_err_r;
    end
  end

  // Stage 5: seconds and the reciprocal product for the weekday.
  logic signed [37:0] s5_daysec;
  logic [34:0]        s5_secs_nxt;
  logic [18:0]        s5_wk_nxt;
  logic [38:0]        s5_q7_nxt;

  always_comb begin
    s5_daysec   = s4_days_r * c2e_pkg::SECS_PER_DAY;
    s5_secs_nxt = 35'(s5_daysec) + 35'(s4_hms_r);
    // The day count is at least minus one, so the shifted count is never negative.
    s5_wk_nxt   = 19'(s4_days_r + c2e_pkg::EPOCH_WEEKDAY);
    s5_q7_nxt   = 39'(s5_wk_nxt) * c2e_pkg::DIV7_MUL;
  end

  logic [34:0] s5_secs_r;
  logic [18:0] s5_wk_r;
  logic [38:0] s5_q7_r;
  logic [8:0]  s5_yday_r;
  logic        s5_err_r;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s5_secs_r <= s5_secs_nxt;
      s5_wk_r   <= s5_wk_nxt;
      s5_q7_r   <= s5_q7_nxt;
      s5_yday_r <= s4_yday_r[8:0];
      s5_err_r  <= s4_err_r;
    end
  end

  // Stage 6: weekday remainder and the output register.
  logic [16:0] s6_quot;
  logic [18:0] s6_rem;

  always_comb begin
    s6_quot = s5_q7_r[38:c2e_pkg::DIV7_SHIFT];
    s6_rem  = s5_wk_r - 19'(19'(s6_quot) * c2e_pkg::DAYS_PER_WEEK);
  end

  logic [34:0] s6_secs_r;
  logic [2:0]  s6_wday_r;
  logic [8:0]  s6_yday_r;
  logic        s6_err_r;

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      s6_secs_r <= s5_err_r ? '0 : s5_secs_r;
      s6_wday_r <= s5_err_r ? '0 : s6_rem[2:0];
      s6_yday_r <= s5_err_r ? '0 : s5_yday_r;
      s6_err_r  <= s5_err_r;
    end
  end

  assign out_if.epoch_seconds = s6_secs_r;
  assign out_if.weekday       = s6_wday_r;
  assign out_if.year_day      = s6_yday_r;
  assign out_if.before_epoch  = s6_err_r;

endmodule

// ===== verif/calendar_to_epoch_seconds_tb.sv =====
// Testbench for calendar_to_epoch_seconds: directed and random dates checked against a predictor.
`timescale 1ns / 100ps

module calendar_to_epoch_seconds_tb;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_DATES = 1530;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_GAP = 17;
  // The receiver stops taking results for this long once, so that the pipeline fills up.
  localparam int HOLD_AT_RESULT = 400;
  localparam int HOLD_CYCLES = 200;
  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic [34:0] epoch_seconds;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
    logic        before_epoch;
  } epoch_t;

  class epoch_tracker;
    epoch_t      pending_q[$];
    int unsigned failures;

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function longint leap_count(input longint n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function epoch_t convert_date(input logic [9:0] ys, input logic [3:0] mon,
                                  input logic [4:0] mday, input logic [4:0] hr,
                                  input logic [5:0] mn, input logic [5:0] sc);
      epoch_t res;
      longint year;
      longint yday;
      longint days;
      longint wday;
      longint secs;
      int     m;
      res = '0;
      if (ys < 10'd70) begin
        res.before_epoch = 1'b1;
        return res;
      end
      m = (mon > 4'd11) ? 11 : int'(mon);
      year = 1900 + longint'(ys);
      yday = MONTH_START[m] + longint'(mday) - 1;
      if (m > 1 && (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0)))
        yday = yday + 1;
      days = (year - 1970) * 365 + leap_count(year - 1) - leap_count(1969) + yday;
      // Day zero of January 1970 gives a negative count; keep the remainder positive.
      wday = (days + 4) % 7;
      if (wday < 0)
        wday = wday + 7;
      secs = ((days * 24 + longint'(hr)) * 60 + longint'(mn)) * 60 + longint'(sc);
      res.epoch_seconds = secs[34:0];
      res.weekday = wday[2:0];
      res.year_day = yday[8:0];
      return res;
    endfunction

    function void note_request(input logic [9:0] ys, input logic [3:0] mon,
                               input logic [4:0] mday, input logic [4:0] hr,
                               input logic [5:0] mn, input logic [5:0] sc);
      pending_q.push_back(convert_date(ys, mon, mday, hr, mn, sc));
    endfunction

    function void check_result(input epoch_t got);
      epoch_t exp_res;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected: epoch_seconds %0d weekday %0d year_day %0d",
                 $time, got.epoch_seconds, got.weekday, got.year_day);
        failures++;
        return;
      end
      exp_res = pending_q.pop_front();
      if (got.epoch_seconds !== exp_res.epoch_seconds) begin
        $display("%0t: epoch_seconds expected %0d, got %0d", $time,
                 exp_res.epoch_seconds, got.epoch_seconds);
        failures++;
      end
      if (got.weekday !== exp_res.weekday) begin
        $display("%0t: weekday expected %0d, got %0d", $time, exp_res.weekday, got.weekday);
        failures++;
      end
      if (got.year_day !== exp_res.year_day) begin
        $display("%0t: year_day expected %0d, got %0d", $time, exp_res.year_day, got.year_day);
        failures++;
      end
      if (got.before_epoch !== exp_res.before_epoch) begin
        $display("%0t: before_epoch expected %0d, got %0d", $time,
                 exp_res.before_epoch, got.before_epoch);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int unsigned results_seen;
  bit sender_eager;

  epoch_tracker tracker = new();

  c2e_in_if  req_if ();
  c2e_out_if res_if ();

  calendar_to_epoch_seconds DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_if),
    .out_if(res_if)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one date from a falling edge, records it when taken, then idles for a drawn gap.
  task automatic send_date(input logic [9:0] ys, input logic [3:0] mon, input logic [4:0] mday,
                           input logic [4:0] hr, input logic [5:0] mn, input logic [5:0] sc);
    int gap;
    req_if.valid <= 1'b1;
    req_if.year_since_1900 <= ys;
    req_if.month <= mon;
    req_if.day_of_month <= mday;
    req_if.hour <= hr;
    req_if.minute <= mn;
    req_if.second <= sc;
    @(posedge clk);
    while (!req_if.ready)
      @(posedge clk);
    tracker.note_request(ys, mon, mday, hr, mn, sc);
    @(negedge clk);
    if ($urandom_range(0, 39) == 0)
      sender_eager = !sender_eager;
    gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random_date();
    logic [9:0] ys;
    logic [3:0] mon;
    logic [4:0] mday;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [5:0] sc;
    int pick;
    pick = $urandom_range(0, 99);
    ys = 10'($urandom);
    mon = 4'($urandom);
    mday = 5'($urandom);
    hr = 5'($urandom);
    mn = 6'($urandom);
    sc = 6'($urandom);
    if (pick < 72) begin
      ys = 10'($urandom_range(70, 1023));
      mon = 4'($urandom_range(0, 11));
      mday = 5'($urandom_range(1, 31));
      hr = 5'($urandom_range(0, 23));
      mn = 6'($urandom_range(0, 59));
      sc = 6'($urandom_range(0, 60));
    end else if (pick < 84) begin
      ys = 10'($urandom_range(0, 69));
    end
    send_date(ys, mon, mday, hr, mn, sc);
  endtask

  // Lowers valid and waits at falling edges until every request has produced its result.
  task automatic drain_requests();
    if (tracker.pending() > 0) begin
      req_if.valid <= 1'b0;
      while (tracker.pending() > 0)
        @(negedge clk);
    end
  endtask

  initial begin : receiver
    int  stall;
    bit  steady;
    epoch_t got;
    stall = 0;
    steady = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        got.epoch_seconds = res_if.epoch_seconds;
        got.weekday = res_if.weekday;
        got.year_day = res_if.year_day;
        got.before_epoch = res_if.before_epoch;
        tracker.check_result(got);
        results_seen++;
        if ($urandom_range(0, 31) == 0)
          steady = !steady;
        if (results_seen == HOLD_AT_RESULT)
          stall = HOLD_CYCLES;
        else
          stall = steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      @(negedge clk);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    cycle_count = 0;
    results_seen = 0;
    sender_eager = 1'b0;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.year_since_1900 = '0;
    req_if.month = '0;
    req_if.day_of_month = '0;
    req_if.hour = '0;
    req_if.minute = '0;
    req_if.second = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Years before 1970, the epoch itself and day zero of January 1970.
    send_date(10'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(10'd69, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60);
    send_date(10'd0, 4'd15, 5'd0, 5'd31, 6'd63, 6'd63);
    send_date(10'd70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(10'd70, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_date(10'd70, 4'd0, 5'd0, 5'd23, 6'd59, 6'd59);
    // Leap years, the century exception and the fourth century.
    send_date(10'd72, 4'd1, 5'd29, 5'd12, 6'd0, 6'd0);
    send_date(10'd72, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(10'd100, 4'd2, 5'd1, 5'd6, 6'd30, 6'd15);
    send_date(10'd200, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(10'd201, 4'd2, 5'd0, 5'd0, 6'd0, 6'd0);
    send_date(10'd500, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60);
    // Months above December, days past the month end and time fields out of range.
    send_date(10'd70, 4'd12, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(10'd71, 4'd14, 5'd0, 5'd1, 6'd2, 6'd3);
    send_date(10'd80, 4'd5, 5'd31, 5'd0, 6'd0, 6'd0);
    send_date(10'd70, 4'd3, 5'd15, 5'd31, 6'd63, 6'd63);
    send_date(10'd99, 4'd1, 5'd28, 5'd12, 6'd30, 6'd30);
    send_date(10'd138, 4'd0, 5'd19, 5'd3, 6'd14, 6'd8);
    send_date(10'd512, 4'd7, 5'd16, 5'd17, 6'd45, 6'd1);
    // Largest year, in range and with every field at its widest.
    send_date(10'd1023, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60);
    send_date(10'd1023, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    drain_requests();

    for (int i = 0; i < RANDOM_DATES; i++) begin
      send_random_date();
      if (i == RANDOM_DATES / 2)
        drain_requests();
    end
    drain_requests();

    repeat (c2e_pkg::NUM_STAGES + 10) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
